/* hw/rtl/packed_yuyv_to_tiled_yuv420_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the packed 4:2:2 to tiled 4:2:0 unit
// Clocked on clk_i, disabled while rst_ni is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PACKED_YUYV_TO_TILED_YUV420_UNIT_MACROS_SVH
`define PACKED_YUYV_TO_TILED_YUV420_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge out of reset
`define PYT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds
`define PYT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PYT_ASSERT(lbl, prop, msg)
`define PYT_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* hw/rtl/pyt_pkg.sv */
// ----------------------------------------------------------------------------
// pyt_pkg
// Shared types and constants of the packed 4:2:2 to tiled 4:2:0 unit.
// ----------------------------------------------------------------------------
package pyt_pkg;

  // Field widths
  localparam int unsigned ByteW       = 8;
  localparam int unsigned LumaAddrW   = 22;
  localparam int unsigned ChromaAddrW = 23;
  localparam int unsigned FirstRowW   = 7;
  localparam int unsigned InDataW     = 32;
  localparam int unsigned OutDataW    = 80;
  localparam int unsigned CfgIdxW     = 2;

  // Widest position values carried between stages
  localparam int unsigned MbRowMaxW   = 9;
  localparam int unsigned PairColMaxW = 11;

  // Register reset values
  localparam logic [7:0] MbColsRst      = 8'd40;
  localparam logic [7:0] PlaneMbRowsRst = 8'd30;
  localparam logic [6:0] FirstMbRowRst  = 7'd0;
  localparam logic [7:0] MbRowCountRst  = 8'd30;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegMbCols      = 2'd0,
    RegPlaneMbRows = 2'd1,
    RegFirstMbRow  = 2'd2,
    RegMbRowCount  = 2'd3
  } reg_idx_e;

  // Item held between position tracking and address generation
  typedef struct packed {
    logic [MbRowMaxW-1:0]   mb_row;
    logic [3:0]             row_in_mb;
    logic [PairColMaxW-1:0] pair_col;
    logic [ByteW-1:0]       luma_first;
    logic [ByteW-1:0]       chroma_blue;
    logic [ByteW-1:0]       luma_second;
    logic [ByteW-1:0]       chroma_red;
    logic                   frame_end;
  } item_t;

endpackage

/* hw/rtl/pyt_position.sv */
// ----------------------------------------------------------------------------
// pyt_position
// Tracks column pair and row of the incoming stream, drops words outside
// the region and registers each converted word with its position.
// ----------------------------------------------------------------------------
`include "packed_yuyv_to_tiled_yuv420_unit_macros.svh"

module pyt_position #(
  parameter int unsigned MAX_MB_COLS = 128,
  parameter int unsigned MAX_MB_ROWS = 128
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [$clog2(MAX_MB_COLS+1)-1:0]       cols_i,
  input  logic [$clog2(MAX_MB_ROWS+1)-1:0]       row_count_i,
  input  logic [pyt_pkg::FirstRowW-1:0]          first_mb_row_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [pyt_pkg::InDataW-1:0]            in_data_i,
  input  logic                                   advance_i,
  output logic                                   item_valid_o,
  output pyt_pkg::item_t                         item_o
);

  localparam int unsigned ColsW  = $clog2(MAX_MB_COLS + 1);
  localparam int unsigned CountW = $clog2(MAX_MB_ROWS + 1);
  localparam int unsigned PairsW = ColsW + 3;
  localparam int unsigned RowsW  = CountW + 4;
  localparam int unsigned PcW    = $clog2(MAX_MB_COLS * 8);
  localparam int unsigned RowW   = $clog2(MAX_MB_ROWS * 16);

  logic [PcW-1:0]    pair_col_q, pair_col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic              done_q, done_d;
  logic              item_valid_q, item_valid_d;
  pyt_pkg::item_t    item_q, item_d;

  logic [PairsW-1:0] pairs;
  logic [RowsW-1:0]  rows;
  logic [PairsW-1:0] pair_col_inc;
  logic [RowsW-1:0]  row_inc;
  logic              accept;
  logic              in_region;
  logic              last_col;
  logic              last_row;

  // Row length in pairs and region height in rows
  assign pairs        = {cols_i, 3'b000};
  assign rows         = {row_count_i, 4'b0000};
  assign pair_col_inc = PairsW'(pair_col_q) + PairsW'(1);
  assign row_inc      = RowsW'(row_q) + RowsW'(1);
  assign last_col     = pair_col_inc >= pairs;
  assign last_row     = row_inc >= rows;
  assign in_region    = !done_q && (RowsW'(row_q) < rows);

  // Stage loads whenever it is empty or its item moves on
  assign in_ready_o = !item_valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  // Advance position on each accepted item
  always_comb begin
    pair_col_d = pair_col_q;
    row_d      = row_q;
    done_d     = done_q;
    if (accept && !done_q) begin
      if (!in_region) begin
        done_d = 1'b1;
      end else if (last_col) begin
        pair_col_d = '0;
        row_d      = RowW'(row_inc);
        done_d     = last_row;
      end else begin
        pair_col_d = PcW'(pair_col_inc);
      end
    end
  end

  // Capture the item with its position
  always_comb begin
    item_valid_d          = in_ready_o ? (accept && in_region) : item_valid_q;
    item_d.mb_row         = pyt_pkg::MbRowMaxW'(first_mb_row_i)
                          + pyt_pkg::MbRowMaxW'(row_q >> 4);
    item_d.row_in_mb      = row_q[3:0];
    item_d.pair_col       = pyt_pkg::PairColMaxW'(pair_col_q);
    item_d.luma_first     = in_data_i[7:0];
    item_d.chroma_blue    = in_data_i[15:8];
    item_d.luma_second    = in_data_i[23:16];
    item_d.chroma_red     = in_data_i[31:24];
    item_d.frame_end      = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_col_q   <= '0;
      row_q        <= '0;
      done_q       <= 1'b0;
      item_valid_q <= 1'b0;
    end else begin
      pair_col_q   <= pair_col_d;
      row_q        <= row_d;
      done_q       <= done_d;
      item_valid_q <= item_valid_d;
    end
  end

  // Payload loads only with a converted item
  always_ff @(posedge clk_i) begin
    if (accept && in_region) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

  `PYT_ASSERT(a_done_sticks, done_q |=> done_q, "region end flag cleared")
  `PYT_ASSERT(a_no_item_after_end, (done_q && accept) |=> !item_valid_q,
              "item passed after region end")
  `PYT_ASSERT(a_held_item_stable, (item_valid_q && !advance_i) |=>
              (item_valid_q && $stable(item_q)), "held item changed")

endmodule

/* hw/rtl/pyt_addr_gen.sv */
// ----------------------------------------------------------------------------
// pyt_addr_gen
// Forms the tiled luma and chroma byte addresses of one item and holds
// the result in the output register.
// ----------------------------------------------------------------------------
`include "packed_yuyv_to_tiled_yuv420_unit_macros.svh"

module pyt_addr_gen #(
  parameter int unsigned MAX_MB_COLS = 128,
  parameter int unsigned MAX_MB_ROWS = 128
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [$clog2(MAX_MB_COLS+1)-1:0]       cols_i,
  input  logic [$clog2(MAX_MB_ROWS+1)-1:0]       plane_rows_i,
  input  logic                                   item_valid_i,
  input  pyt_pkg::item_t                         item_i,
  output logic                                   advance_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [pyt_pkg::LumaAddrW-1:0]          luma_address_o,
  output logic [pyt_pkg::ByteW-1:0]              luma_low_o,
  output logic [pyt_pkg::ByteW-1:0]              luma_high_o,
  output logic                                   chroma_valid_o,
  output logic [pyt_pkg::ChromaAddrW-1:0]        chroma_address_o,
  output logic [pyt_pkg::ByteW-1:0]              u_out_o,
  output logic [pyt_pkg::ByteW-1:0]              v_out_o,
  output logic                                   frame_end_o
);

  localparam int unsigned ColsW  = $clog2(MAX_MB_COLS + 1);
  localparam int unsigned PlaneW = $clog2(MAX_MB_ROWS + 1);
  localparam int unsigned ProdW  = ColsW + pyt_pkg::MbRowMaxW;
  localparam int unsigned BlkW   = ProdW + 1;

  logic [ColsW+PlaneW-1:0]           plane_blocks;
  logic [pyt_pkg::ChromaAddrW-1:0]   base_q;
  logic [ProdW-1:0]                  row_blocks;
  logic [BlkW-1:0]                   blk;
  logic                              even_row;

  logic                              out_valid_q, out_valid_d;
  logic [pyt_pkg::LumaAddrW-1:0]     luma_address_q, luma_address_d;
  logic [pyt_pkg::ByteW-1:0]         luma_low_q, luma_high_q;
  logic                              chroma_valid_q;
  logic [pyt_pkg::ChromaAddrW-1:0]   chroma_address_q, chroma_address_d;
  logic [pyt_pkg::ByteW-1:0]         u_out_q, v_out_q;
  logic                              frame_end_q;

  // Chroma plane starts after the padded luma plane
  assign plane_blocks = cols_i * plane_rows_i;

  always_ff @(posedge clk_i) begin
    base_q <= pyt_pkg::ChromaAddrW'({plane_blocks, 8'h00});
  end

  // Macroblock index in raster order
  assign row_blocks = cols_i * item_i.mb_row;
  assign blk        = BlkW'(row_blocks)
                    + BlkW'(item_i.pair_col[pyt_pkg::PairColMaxW-1:3]);
  assign even_row   = !item_i.row_in_mb[0];

  // Luma: 16 bytes per row inside a block, chroma: U then V per row
  assign luma_address_d   = pyt_pkg::LumaAddrW'({blk, item_i.row_in_mb,
                                                 item_i.pair_col[2:0], 1'b0});
  assign chroma_address_d = pyt_pkg::ChromaAddrW'({blk, item_i.row_in_mb[3:1], 1'b0,
                                                   item_i.pair_col[2:0]}) + base_q;

  // Output register frees up when empty or taken
  assign advance_o   = !out_valid_q || out_ready_i;
  assign out_valid_d = advance_o ? item_valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load result payload; zero chroma on odd rows
  always_ff @(posedge clk_i) begin
    if (advance_o && item_valid_i) begin
      luma_address_q   <= luma_address_d;
      luma_low_q       <= item_i.luma_first;
      luma_high_q      <= item_i.luma_second;
      chroma_valid_q   <= even_row;
      chroma_address_q <= even_row ? chroma_address_d : '0;
      u_out_q          <= even_row ? item_i.chroma_blue : '0;
      v_out_q          <= even_row ? item_i.chroma_red : '0;
      frame_end_q      <= item_i.frame_end;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign luma_address_o   = luma_address_q;
  assign luma_low_o       = luma_low_q;
  assign luma_high_o      = luma_high_q;
  assign chroma_valid_o   = chroma_valid_q;
  assign chroma_address_o = chroma_address_q;
  assign u_out_o          = u_out_q;
  assign v_out_o          = v_out_q;
  assign frame_end_o      = frame_end_q;

  `PYT_ASSERT_NEVER(a_odd_row_chroma_zero, out_valid_q && !chroma_valid_q &&
                    (chroma_address_q != '0 || u_out_q != '0 || v_out_q != '0),
                    "chroma fields set on an odd row")

endmodule

/* hw/rtl/packed_yuyv_to_tiled_yuv420_unit.sv */
// ----------------------------------------------------------------------------
// packed_yuyv_to_tiled_yuv420_unit
// Address generator from packed 4:2:2 words to 16x16 tiled 4:2:0 planes.
// ----------------------------------------------------------------------------
// Takes one packed word (Y0, U, Y1, V) per cycle in raster order and returns
// one result per cycle: the tiled luma byte address with both luma bytes
// and, on even source rows, the chroma address with U and V (V lands eight
// bytes after U). Each word passes through the position register and then
// the output register, with a single macroblock-index multiply between
// them; a full item rate of one per cycle holds as long as results are
// taken. Words past the last converted macroblock row are consumed and give
// no result until reset. Configuration register writes take effect for the
// next word, the column count also for a word held in the position register.
// ----------------------------------------------------------------------------

module packed_yuyv_to_tiled_yuv420_unit #(
  parameter int unsigned MAX_MB_COLS = 128,
  parameter int unsigned MAX_MB_ROWS = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pyt_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  // Source words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
  input  logic [pyt_pkg::InDataW-1:0]         s_axis_tdata,
  // Results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // luma_address[21:0], luma_low[29:22], luma_high[37:30],
  // chroma_address[60:38], u_out[68:61], v_out[76:69], zero[79:77]
  output logic [pyt_pkg::OutDataW-1:0]        m_axis_tdata,
  // chroma_valid[0]
  output logic                                m_axis_tuser,
  // frame_end
  output logic                                m_axis_tlast
);

  localparam int unsigned ColsW  = $clog2(MAX_MB_COLS + 1);
  localparam int unsigned CountW = $clog2(MAX_MB_ROWS + 1);

  logic [7:0]                        mb_cols_q;
  logic [7:0]                        plane_mb_rows_q;
  logic [pyt_pkg::FirstRowW-1:0]     first_mb_row_q;
  logic [7:0]                        mb_row_count_q;

  logic [ColsW-1:0]                  cols;
  logic [CountW-1:0]                 plane_rows;
  logic [CountW-1:0]                 row_count;

  logic                              item_valid;
  pyt_pkg::item_t                    item;
  logic                              advance;

  logic [pyt_pkg::LumaAddrW-1:0]     luma_address;
  logic [pyt_pkg::ByteW-1:0]         luma_low;
  logic [pyt_pkg::ByteW-1:0]         luma_high;
  logic [pyt_pkg::ChromaAddrW-1:0]   chroma_address;
  logic [pyt_pkg::ByteW-1:0]         u_out;
  logic [pyt_pkg::ByteW-1:0]         v_out;

  // Register writes always complete
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mb_cols_q       <= pyt_pkg::MbColsRst;
      plane_mb_rows_q <= pyt_pkg::PlaneMbRowsRst;
      first_mb_row_q  <= pyt_pkg::FirstMbRowRst;
      mb_row_count_q  <= pyt_pkg::MbRowCountRst;
    end else if (cfg_valid_i) begin
      unique case (pyt_pkg::reg_idx_e'(cfg_index_i))
        pyt_pkg::RegMbCols:      mb_cols_q       <= cfg_data_i;
        pyt_pkg::RegPlaneMbRows: plane_mb_rows_q <= cfg_data_i;
        pyt_pkg::RegFirstMbRow:  first_mb_row_q  <= cfg_data_i[pyt_pkg::FirstRowW-1:0];
        pyt_pkg::RegMbRowCount:  mb_row_count_q  <= cfg_data_i;
      endcase
    end
  end

  // Clamp register values to their legal ranges
  always_comb begin
    if (mb_cols_q == '0) begin
      cols = ColsW'(1);
    end else if (32'(mb_cols_q) > MAX_MB_COLS) begin
      cols = ColsW'(MAX_MB_COLS);
    end else begin
      cols = ColsW'(mb_cols_q);
    end

    if (plane_mb_rows_q == '0) begin
      plane_rows = CountW'(1);
    end else if (32'(plane_mb_rows_q) > MAX_MB_ROWS) begin
      plane_rows = CountW'(MAX_MB_ROWS);
    end else begin
      plane_rows = CountW'(plane_mb_rows_q);
    end

    if (mb_row_count_q == '0) begin
      row_count = CountW'(1);
    end else if (32'(mb_row_count_q) > MAX_MB_ROWS) begin
      row_count = CountW'(MAX_MB_ROWS);
    end else begin
      row_count = CountW'(mb_row_count_q);
    end
  end

  pyt_position #(
    .MAX_MB_COLS (MAX_MB_COLS),
    .MAX_MB_ROWS (MAX_MB_ROWS)
  ) u_position (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cols_i         (cols),
    .row_count_i    (row_count),
    .first_mb_row_i (first_mb_row_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_data_i      (s_axis_tdata),
    .advance_i      (advance),
    .item_valid_o   (item_valid),
    .item_o         (item)
  );

  pyt_addr_gen #(
    .MAX_MB_COLS (MAX_MB_COLS),
    .MAX_MB_ROWS (MAX_MB_ROWS)
  ) u_addr_gen (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cols_i           (cols),
    .plane_rows_i     (plane_rows),
    .item_valid_i     (item_valid),
    .item_i           (item),
    .advance_o        (advance),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .luma_address_o   (luma_address),
    .luma_low_o       (luma_low),
    .luma_high_o      (luma_high),
    .chroma_valid_o   (m_axis_tuser),
    .chroma_address_o (chroma_address),
    .u_out_o          (u_out),
    .v_out_o          (v_out),
    .frame_end_o      (m_axis_tlast)
  );

  // Pack result fields, lowest field first
  assign m_axis_tdata = {3'b000, v_out, u_out, chroma_address,
                         luma_high, luma_low, luma_address};

endmodule
